[rtl/fpc_pkg.sv]
// Shared types, constants and helpers for the float to PCM converter.
package fpc_pkg;

	typedef enum logic [1:0] {
		DEPTH_16 = 2'd0,
		DEPTH_24 = 2'd1,
		DEPTH_32 = 2'd2
	} depth_t;

	localparam logic [1:0] DEPTH_RSVD = 2'd3;
	localparam logic [1:0] REG_DEPTH_MODE = 2'd0;

	localparam logic [30:0] SCALE_16 = 31'd32767;
	localparam logic [30:0] SCALE_24 = 31'd8388607;
	localparam logic [30:0] SCALE_32 = 31'd2147483647;

	// Exponent bias plus fraction width: value = mant * 2^(exp - EXP_OFFSET).
	localparam logic [7:0] EXP_OFFSET = 8'd150;
	localparam logic [7:0] EXP_ONE = 8'd127;
	localparam logic [7:0] EXP_MAX = 8'd255;

	typedef struct packed {
		logic        eob;
		depth_t      depth;
		logic        sign;
		logic        zero;
		logic [7:0]  exp;
		logic [23:0] mant;
	} s1_t;

	typedef struct packed {
		logic        eob;
		depth_t      depth;
		logic        sign;
		logic        zero;
		logic [7:0]  exp;
		logic [54:0] prod;
	} s2_t;

	typedef struct packed {
		logic        eob;
		depth_t      depth;
		logic        sign;
		logic        zero;
		logic [7:0]  exp;
		logic [55:0] rounded;
	} s3_t;

	typedef struct packed {
		logic        eob;
		depth_t      depth;
		logic        sign;
		logic [31:0] mag;
	} s4_t;

	function automatic logic [30:0] scale_of(depth_t d);
		logic [30:0] s;
		unique case (d)
			DEPTH_16: s = SCALE_16;
			DEPTH_24: s = SCALE_24;
			default:  s = SCALE_32;
		endcase
		return s;
	endfunction

endpackage

[rtl/fpc_decode.sv]
// Input stage: unpacks the float, clamps to [-1,1] and flags NaN and tiny values.
module fpc_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [31:0]    sample_bits,
	input  logic           end_of_buffer,
	input  fpc_pkg::depth_t depth,
	output logic           v_s1,
	output fpc_pkg::s1_t   d_s1
);

	logic [7:0]   exp;
	logic [22:0]  frac;
	logic         is_nan;
	logic         is_big;
	fpc_pkg::s1_t nxt;

	always_comb begin
		exp = sample_bits[30:23];
		frac = sample_bits[22:0];
		is_nan = (exp == fpc_pkg::EXP_MAX) && (frac != 23'd0);
		is_big = (exp > fpc_pkg::EXP_ONE) || ((exp == fpc_pkg::EXP_ONE) && (frac != 23'd0));
		nxt.eob = end_of_buffer;
		nxt.depth = depth;
		nxt.sign = sample_bits[31];
		// Subnormals and zero scale to well under one half, so they give zero.
		nxt.zero = is_nan || (exp == 8'd0);
		nxt.exp = is_big ? fpc_pkg::EXP_ONE : exp;
		nxt.mant = is_big ? 24'h800000 : {1'b1, frac};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= nxt;
	end

endmodule

[rtl/fpc_scale.sv]
// Scaling stages: exact product, then rounding to float or double precision.
module fpc_scale (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         v_s1,
	input  fpc_pkg::s1_t d_s1,
	output logic         v_s3,
	output fpc_pkg::s3_t d_s3
);

	logic         v_s2;
	fpc_pkg::s2_t d_s2;
	fpc_pkg::s3_t nxt3;
	logic [5:0]   drop;
	logic [5:0]   drop_m1;
	logic         lsb;
	logic         guard;
	logic         sticky;
	logic [54:0]  keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s2.eob <= d_s1.eob;
		d_s2.depth <= d_s1.depth;
		d_s2.sign <= d_s1.sign;
		d_s2.zero <= d_s1.zero;
		d_s2.exp <= d_s1.exp;
		d_s2.prod <= 55'(d_s1.mant) * 55'(fpc_pkg::scale_of(d_s1.depth));
	end

	// The leading one sits at one of two known places, so the number of
	// dropped bits follows from a single product bit.
	always_comb begin
		unique case (d_s2.depth)
			fpc_pkg::DEPTH_16: drop = d_s2.prod[38] ? 6'd15 : 6'd14;
			fpc_pkg::DEPTH_24: drop = d_s2.prod[46] ? 6'd23 : 6'd22;
			default:           drop = d_s2.prod[54] ? 6'd2 : 6'd1;
		endcase
		drop_m1 = drop - 6'd1;
		lsb = d_s2.prod[drop];
		guard = d_s2.prod[drop_m1];
		sticky = |(d_s2.prod & ((55'd1 << drop_m1) - 55'd1));
		keep = d_s2.prod & ~((55'd1 << drop) - 55'd1);
		nxt3.eob = d_s2.eob;
		nxt3.depth = d_s2.depth;
		nxt3.sign = d_s2.sign;
		nxt3.zero = d_s2.zero;
		nxt3.exp = d_s2.exp;
		nxt3.rounded = {1'b0, keep} + ((guard && (sticky || lsb)) ? (56'd1 << drop) : 56'd0);
	end

	always_ff @(posedge clk) begin
		d_s3 <= nxt3;
	end

endmodule

[rtl/fpc_quantize.sv]
// Output stages: rounding to integer half away from zero, sign and byte packing.
module fpc_quantize (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         v_s3,
	input  fpc_pkg::s3_t d_s3,
	output logic         result_valid,
	output logic [31:0]  pcm_bytes,
	output logic [2:0]   byte_count,
	output logic         end_of_packet
);

	logic         v_s4;
	fpc_pkg::s4_t d_s4;
	fpc_pkg::s4_t nxt4;
	logic [7:0]   sh;
	logic [7:0]   sh_m1;
	logic [55:0]  whole;
	logic         half;
	logic [31:0]  signed_val;
	logic [31:0]  pcm_q;
	logic [2:0]   count_q;
	logic         eop_q;
	logic         valid_q;

	always_comb begin
		sh = fpc_pkg::EXP_OFFSET - d_s3.exp;
		sh_m1 = sh - 8'd1;
		whole = d_s3.rounded >> sh;
		half = d_s3.rounded[sh_m1[5:0]];
		nxt4.eob = d_s3.eob;
		nxt4.depth = d_s3.depth;
		nxt4.sign = d_s3.sign;
		if (d_s3.zero || (sh > 8'd56)) begin
			nxt4.mag = 32'd0;
		end else begin
			nxt4.mag = whole[31:0] + {31'd0, half};
		end
	end

	always_comb begin
		signed_val = d_s4.sign ? (32'd0 - d_s4.mag) : d_s4.mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			v_s4 <= v_s3;
			valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		d_s4 <= nxt4;
		eop_q <= d_s4.eob;
		unique case (d_s4.depth)
			fpc_pkg::DEPTH_16: begin
				pcm_q <= {16'd0, signed_val[15:0]};
				count_q <= 3'd2;
			end
			fpc_pkg::DEPTH_24: begin
				pcm_q <= {8'd0, signed_val[23:0]};
				count_q <= 3'd3;
			end
			default: begin
				pcm_q <= signed_val;
				count_q <= 3'd4;
			end
		endcase
	end

	assign result_valid = valid_q;
	assign pcm_bytes = pcm_q;
	assign byte_count = count_q;
	assign end_of_packet = eop_q;

endmodule

[rtl/float_to_pcm_converter.sv]
// Top level of the float32 to signed PCM converter with its register port.
// A beat accepted at one clock edge passes in order through the register stages listed
// below, and result_valid is high for exactly one cycle with each result.
// Throughput: one beat per cycle; busy is always low and the receiver cannot stall.
// Five register stages: decode and clamp, 24x31 multiply, precision rounding,
// integer rounding shift, sign and byte packing.
// Reset (arst_n low, asynchronous) clears the pipeline valid bits and sets depth_mode to 0.
module float_to_pcm_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] sample_bits,
	input  logic        end_of_buffer,
	output logic        result_valid,
	output logic [31:0] pcm_bytes,
	output logic [2:0]  byte_count,
	output logic        end_of_packet,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	fpc_pkg::depth_t depth_q;
	logic            cfg_wr;
	logic            in_valid;
	logic            v_s1;
	fpc_pkg::s1_t    d_s1;
	logic            v_s3;
	fpc_pkg::s3_t    d_s3;

	// The pipeline never holds back, so every start beat is taken.
	assign busy = 1'b0;
	assign in_valid = start && !busy;

	// Register port: one register at byte address zero. The reserved depth
	// code is dropped and the register keeps its previous value.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = {30'd0, depth_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= fpc_pkg::DEPTH_16;
		end else if (cfg_wr && (paddr == fpc_pkg::REG_DEPTH_MODE)
				&& (pwdata[1:0] != fpc_pkg::DEPTH_RSVD)) begin
			depth_q <= fpc_pkg::depth_t'(pwdata[1:0]);
		end
	end

	// The depth travels with each beat, so results stay consistent per sample.
	fpc_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.sample_bits   (sample_bits),
		.end_of_buffer (end_of_buffer),
		.depth         (depth_q),
		.v_s1          (v_s1),
		.d_s1          (d_s1)
	);

	// The product is exact; it is then rounded to nearest even at 24 bits for
	// the shorter depths and at 53 bits for the 32-bit depth.
	fpc_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (v_s1),
		.d_s1   (d_s1),
		.v_s3   (v_s3),
		.d_s3   (d_s3)
	);

	// Rounding half away from zero, then negation and byte masking. NaN gives zero.
	fpc_quantize u_quantize (
		.clk           (clk),
		.arst_n        (arst_n),
		.v_s3          (v_s3),
		.d_s3          (d_s3),
		.result_valid  (result_valid),
		.pcm_bytes     (pcm_bytes),
		.byte_count    (byte_count),
		.end_of_packet (end_of_packet)
	);

endmodule
